>>> sv/sfd_pkg.sv
package sfd_pkg;

   localparam int PAYLOAD_BYTES  = 24;
   localparam int ENCODER_COUNT  = 4;
   localparam int DISTANCE_COUNT = 6;
   // Only the leading payload bytes feed the result; the rest are counted and dropped.
   localparam int REPORTED_BYTES = 2 * (ENCODER_COUNT + DISTANCE_COUNT);
   localparam int IDX_W          = $clog2(PAYLOAD_BYTES);

   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   typedef enum logic [4:0] {
      PH_HUNT     = 5'b00001,
      PH_HDR_CR   = 5'b00010,
      PH_PAYLOAD  = 5'b00100,
      PH_TRL_CR   = 5'b01000,
      PH_TRL_LF   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ENCODER_COUNT-1:0][15:0]  encoder;
      logic [DISTANCE_COUNT-1:0][15:0] distance;
   } frame_type;

endpackage

>>> sv/sensor_frame_deframer.sv
// Sensor frame deframer. Each request carries one received serial byte; the block looks
// for frames of the form LF, CR, 24 payload bytes, CR, LF and, for every frame that closes
// correctly, returns one request on the rsp_ channel with four signed encoder speeds and
// six unsigned distances taken as little-endian pairs from payload bytes 0 to 19. A byte
// that breaks the pattern sends the parser back to hunting for LF and is not looked at
// again; repeated LF bytes before the header CR keep the hunt armed. The block takes one
// byte in every cycle while req_stall is low: the parser state and the payload bytes are
// registers that update at the edge that accepts a byte, and the result is loaded at the
// edge that accepts the closing LF into the output register, or into the skid register
// behind it when the output holds a stalled result. The skid register lets bytes keep
// flowing while a result waits; req_stall rises only while both of them hold a result.
module sensor_frame_deframer
   import sfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_encoder_1,
   output logic signed [15:0] rsp_encoder_2,
   output logic signed [15:0] rsp_encoder_3,
   output logic signed [15:0] rsp_encoder_4,
   output logic [15:0]        rsp_distance_1,
   output logic [15:0]        rsp_distance_2,
   output logic [15:0]        rsp_distance_3,
   output logic [15:0]        rsp_distance_4,
   output logic [15:0]        rsp_distance_5,
   output logic [15:0]        rsp_distance_6
);

   logic      byte_accept;
   logic      frame_done;
   logic      buf_full;
   frame_type frame;
   frame_type rsp_frame;

   // A request is held off only while the skid register is occupied.
   assign req_stall   = buf_full;
   assign byte_accept = req_valid && !req_stall;

   sfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   sfd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load_valid (frame_done),
      .load_frame (frame),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_frame  (rsp_frame)
   );

   assign rsp_encoder_1  = signed'(rsp_frame.encoder[0]);
   assign rsp_encoder_2  = signed'(rsp_frame.encoder[1]);
   assign rsp_encoder_3  = signed'(rsp_frame.encoder[2]);
   assign rsp_encoder_4  = signed'(rsp_frame.encoder[3]);
   assign rsp_distance_1 = rsp_frame.distance[0];
   assign rsp_distance_2 = rsp_frame.distance[1];
   assign rsp_distance_3 = rsp_frame.distance[2];
   assign rsp_distance_4 = rsp_frame.distance[3];
   assign rsp_distance_5 = rsp_frame.distance[4];
   assign rsp_distance_6 = rsp_frame.distance[5];

   // A completed frame always finds room, so it is never dropped.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      frame_done |-> !buf_full)
      else $error("frame completed while the skid register was occupied");

   // The skid register is only ever filled behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid register holds a result while the output is empty");

   // After a completed frame, rsp_valid is high in the next cycle; the frame itself may wait in the skid register.
   a_frame_shown: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> rsp_valid)
      else $error("completed frame did not reach the result channel");

endmodule

>>> sv/sfd_parser.sv
module sfd_parser
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       frame_done,
   output frame_type  frame
);

   phase_type              phase_ff, phase_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [7:0]             store_ff [REPORTED_BYTES];

   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      frame_done = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            phase_in = (rx_byte == BYTE_LF) ? PH_HDR_CR : PH_HUNT;
         end
         PH_HDR_CR: begin
            if (rx_byte == BYTE_CR) begin
               index_in = '0;
               phase_in = PH_PAYLOAD;
            end else if (rx_byte != BYTE_LF) begin
               phase_in = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            if (index_ff == IDX_W'(PAYLOAD_BYTES - 1)) begin
               index_in = '0;
               phase_in = PH_TRL_CR;
            end else begin
               index_in = index_ff + IDX_W'(1);
            end
         end
         PH_TRL_CR: begin
            phase_in = (rx_byte == BYTE_CR) ? PH_TRL_LF : PH_HUNT;
         end
         PH_TRL_LF: begin
            phase_in   = PH_HUNT;
            frame_done = byte_accept && (rx_byte == BYTE_LF);
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         index_ff <= '0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   for (genvar i = 0; i < REPORTED_BYTES; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (byte_accept && phase_ff == PH_PAYLOAD && index_ff == IDX_W'(i)) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   // Little-endian pairs: encoders first, distances after them.
   for (genvar k = 0; k < ENCODER_COUNT; k++) begin : g_enc
      assign frame.encoder[k] = {store_ff[2*k+1], store_ff[2*k]};
   end
   for (genvar k = 0; k < DISTANCE_COUNT; k++) begin : g_dist
      assign frame.distance[k] = {store_ff[2*ENCODER_COUNT+2*k+1],
                                  store_ff[2*ENCODER_COUNT+2*k]};
   end

endmodule

>>> sv/sfd_out_buf.sv
module sfd_out_buf
   import sfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load_valid,
   input  frame_type load_frame,
   output logic      full,
   output logic      out_valid,
   input  logic      out_stall,
   output frame_type out_frame
);

   logic      out_valid_ff, out_valid_in;
   frame_type out_frame_ff, out_frame_in;
   logic      skid_valid_ff, skid_valid_in;
   frame_type skid_frame_ff, skid_frame_in;
   logic      out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_frame_in  = out_frame_ff;
      skid_valid_in = skid_valid_ff;
      skid_frame_in = skid_frame_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_frame_in  = skid_frame_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = load_valid;
         out_frame_in = load_frame;
      end else if (load_valid) begin
         skid_valid_in = 1'b1;
         skid_frame_in = load_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_frame_ff  <= out_frame_in;
      skid_frame_ff <= skid_frame_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_frame = out_frame_ff;

endmodule

>>> tb/tb_sensor_frame_deframer.sv
// Self-checking bench for the serial sensor frame deframer.
module tb_sensor_frame_deframer;
   import sfd_pkg::*;

   // A stretch this long with no request accepted on either side means the
   // block has hung.
   localparam int QUIET_LIMIT  = 1000;
   localparam int RANDOM_BYTES = 1180;

   // One row of the directed table. Every row sends a lead byte, a header of
   // LF bytes and one header byte that should be CR, 24 payload bytes and two
   // trailer bytes. The payload is either a fixed even/odd pair or a ramp.
   // Rows marked typed carry their outcome by hand: either no result at all,
   // or one result whose ten fields all equal gold_word.
   typedef struct {
      logic [7:0]  lead;
      int          lf_count;
      logic [7:0]  hdr_cr;
      bit          ramp;
      logic [7:0]  even_byte;
      logic [7:0]  odd_byte;
      logic [7:0]  trl_cr;
      logic [7:0]  trl_lf;
      bit          typed;
      bit          yields;
      logic [15:0] gold_word;
   } case_row_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic signed [15:0] rsp_encoder_1;
   logic signed [15:0] rsp_encoder_2;
   logic signed [15:0] rsp_encoder_3;
   logic signed [15:0] rsp_encoder_4;
   logic [15:0]        rsp_distance_1;
   logic [15:0]        rsp_distance_2;
   logic [15:0]        rsp_distance_3;
   logic [15:0]        rsp_distance_4;
   logic [15:0]        rsp_distance_5;
   logic [15:0]        rsp_distance_6;

   // Readings the block still owes us, oldest first.
   frame_type  reading_q [$];
   // Our own copy of the parser: where it is in the frame and what payload it holds.
   phase_type  frame_phase;
   int         pay_pos;
   logic [7:0] pay_bytes [PAYLOAD_BYTES];

   int  failures    = 0;
   int  bytes_sent  = 0;
   int  quiet_count = 0;
   // When set, neither side inserts idle cycles.
   bit  calm        = 1'b0;
   // When set, the current directed row has pushed its typed outcome already,
   // so the readings worked out by the parser copy are not queued again.
   bit  gold_held   = 1'b0;

   sensor_frame_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_encoder_1  (rsp_encoder_1),
      .rsp_encoder_2  (rsp_encoder_2),
      .rsp_encoder_3  (rsp_encoder_3),
      .rsp_encoder_4  (rsp_encoder_4),
      .rsp_distance_1 (rsp_distance_1),
      .rsp_distance_2 (rsp_distance_2),
      .rsp_distance_3 (rsp_distance_3),
      .rsp_distance_4 (rsp_distance_4),
      .rsp_distance_5 (rsp_distance_5),
      .rsp_distance_6 (rsp_distance_6)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one line per failure and counts every one of them.
   task automatic note_failure(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      failures++;
   endtask

   // Advances the parser copy by one received byte. Returns 1 and fills
   // reading when the byte closes a good frame.
   function automatic bit track_byte(input logic [7:0] b, output frame_type reading);
      reading = '0;
      case (frame_phase)
         PH_HUNT: begin
            frame_phase = (b == BYTE_LF) ? PH_HDR_CR : PH_HUNT;
         end
         PH_HDR_CR: begin
            // Extra LF bytes keep the header armed; anything else but CR drops it.
            if (b == BYTE_CR) begin
               pay_pos     = 0;
               frame_phase = PH_PAYLOAD;
            end else if (b != BYTE_LF) begin
               frame_phase = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            pay_bytes[pay_pos] = b;
            pay_pos++;
            if (pay_pos >= PAYLOAD_BYTES) begin
               pay_pos     = 0;
               frame_phase = PH_TRL_CR;
            end
         end
         PH_TRL_CR: begin
            frame_phase = (b == BYTE_CR) ? PH_TRL_LF : PH_HUNT;
         end
         PH_TRL_LF: begin
            frame_phase = PH_HUNT;
            if (b == BYTE_LF) begin
               for (int k = 0; k < ENCODER_COUNT; k++) begin
                  reading.encoder[k] = {pay_bytes[2*k+1], pay_bytes[2*k]};
               end
               for (int k = 0; k < DISTANCE_COUNT; k++) begin
                  reading.distance[k] = {pay_bytes[2*ENCODER_COUNT+2*k+1],
                                         pay_bytes[2*ENCODER_COUNT+2*k]};
               end
               return 1'b1;
            end
         end
         default: begin
            frame_phase = PH_HUNT;
         end
      endcase
      return 1'b0;
   endfunction

   // Offers one byte as a request, with random idle cycles ahead of it unless
   // the calm stretch is on, and holds it steady until the block takes it.
   task automatic send_byte(input logic [7:0] b);
      frame_type reading;
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
      if (track_byte(b, reading) && !gold_held) begin
         reading_q.push_back(reading);
      end
   endtask

   // Random byte that lands on LF or CR far more often than chance would, so
   // that stray framing bytes show up inside payloads and noise.
   function automatic logic [7:0] noisy_byte();
      if ($urandom_range(7) == 0) begin
         return $urandom_range(1) ? BYTE_LF : BYTE_CR;
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic case_row_type mk_row(input logic [7:0] lead, input int lf_count,
                                           input logic [7:0] hdr_cr, input bit ramp,
                                           input logic [7:0] even_byte,
                                           input logic [7:0] odd_byte,
                                           input logic [7:0] trl_cr,
                                           input logic [7:0] trl_lf,
                                           input bit typed, input bit yields,
                                           input logic [15:0] gold_word);
      case_row_type row;
      row.lead      = lead;
      row.lf_count  = lf_count;
      row.hdr_cr    = hdr_cr;
      row.ramp      = ramp;
      row.even_byte = even_byte;
      row.odd_byte  = odd_byte;
      row.trl_cr    = trl_cr;
      row.trl_lf    = trl_lf;
      row.typed     = typed;
      row.yields    = yields;
      row.gold_word = gold_word;
      return row;
   endfunction

   // Result side: compare every accepted reading field by field with the
   // oldest one still owed, and stall at random outside the calm stretch.
   always @(posedge clock) begin
      frame_type   want;
      logic [15:0] got_enc  [ENCODER_COUNT];
      logic [15:0] got_dist [DISTANCE_COUNT];
      if (!reset && rsp_valid && !rsp_stall) begin
         got_enc  = '{rsp_encoder_1, rsp_encoder_2, rsp_encoder_3, rsp_encoder_4};
         got_dist = '{rsp_distance_1, rsp_distance_2, rsp_distance_3,
                      rsp_distance_4, rsp_distance_5, rsp_distance_6};
         if (reading_q.size() == 0) begin
            note_failure($sformatf("reading with none owed (encoder_1 %h)", got_enc[0]));
         end else begin
            want = reading_q.pop_front();
            for (int k = 0; k < ENCODER_COUNT; k++) begin
               if (got_enc[k] !== want.encoder[k]) begin
                  note_failure($sformatf("encoder_%0d got %h, want %h",
                                         k + 1, got_enc[k], want.encoder[k]));
               end
            end
            for (int k = 0; k < DISTANCE_COUNT; k++) begin
               if (got_dist[k] !== want.distance[k]) begin
                  note_failure($sformatf("distance_%0d got %h, want %h",
                                         k + 1, got_dist[k], want.distance[k]));
               end
            end
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 17);
   end

   // Watchdog: any accepted request on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count < QUIET_LIMIT) begin
         quiet_count <= quiet_count + 1;
      end else begin
         $display("tb_sensor_frame_deframer: done, errors");
         $finish;
      end
   end

   initial begin
      case_row_type directed [12];
      logic [7:0]   seq [$];
      int           random_start;
      int           roll;
      int           lf_n;
      int           spot;

      frame_phase = PH_HUNT;
      pay_pos     = 0;
      foreach (pay_bytes[i]) begin
         pay_bytes[i] = 8'h00;
      end

      // lead, header LFs, header CR, ramp, even, odd, trailer CR, trailer LF,
      // typed, yields, gold word
      // All-zero payload straight out of reset.
      directed[0]  = mk_row(8'h00, 1, BYTE_CR, 0, 8'h00, 8'h00, BYTE_CR, BYTE_LF,
                            1, 1, 16'h0000);
      // Repeated LF ahead of the header CR keeps the hunt armed; all-ones payload.
      directed[1]  = mk_row(8'hFF, 3, BYTE_CR, 0, 8'hFF, 8'hFF, BYTE_CR, BYTE_LF,
                            1, 1, 16'hFFFF);
      // Most negative encoder speed and top-bit-only distance.
      directed[2]  = mk_row(8'h5A, 1, BYTE_CR, 0, 8'h00, 8'h80, BYTE_CR, BYTE_LF,
                            1, 1, 16'h8000);
      // Most positive encoder speed.
      directed[3]  = mk_row(8'hA5, 2, BYTE_CR, 0, 8'hFF, 8'h7F, BYTE_CR, BYTE_LF,
                            1, 1, 16'h7FFF);
      // LF and CR inside the payload are plain data, not framing.
      directed[4]  = mk_row(8'h00, 1, BYTE_CR, 0, BYTE_LF, BYTE_CR, BYTE_CR, BYTE_LF,
                            1, 1, 16'h0D0A);
      // Distinct bytes everywhere, so any swapped or misplaced byte shows.
      directed[5]  = mk_row(8'h33, 1, BYTE_CR, 1, 8'h00, 8'h00, BYTE_CR, BYTE_LF,
                            0, 0, 16'h0000);
      // Header LF followed by something other than CR or LF: back to the hunt.
      directed[6]  = mk_row(8'h41, 1, 8'h41, 0, 8'h55, 8'h55, BYTE_CR, BYTE_LF,
                            1, 0, 16'h0000);
      // CR with no LF ahead of it never opens a frame.
      directed[7]  = mk_row(8'h00, 0, BYTE_CR, 0, 8'h55, 8'h55, BYTE_CR, BYTE_LF,
                            1, 0, 16'h0000);
      // Trailer CR replaced by LF: the LF is dropped, so the CR after it
      // must not open a new frame.
      directed[8]  = mk_row(8'h00, 1, BYTE_CR, 1, 8'h00, 8'h00, BYTE_LF, BYTE_CR,
                            1, 0, 16'h0000);
      // Closing byte is CR instead of LF: the frame is lost.
      directed[9]  = mk_row(8'h00, 1, BYTE_CR, 0, 8'h12, 8'h34, BYTE_CR, BYTE_CR,
                            1, 0, 16'h0000);
      // Closing byte is some other value.
      directed[10] = mk_row(8'h00, 1, BYTE_CR, 0, 8'hAB, 8'hCD, BYTE_CR, 8'hFF,
                            1, 0, 16'h0000);
      // A clean frame after all the broken ones shows the parser recovered.
      directed[11] = mk_row(8'h77, 2, BYTE_CR, 1, 8'h00, 8'h00, BYTE_CR, BYTE_LF,
                            0, 0, 16'h0000);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         gold_held = directed[r].typed;
         if (directed[r].typed && directed[r].yields) begin
            reading_q.push_back(frame_type'({(ENCODER_COUNT + DISTANCE_COUNT)
                                             {directed[r].gold_word}}));
         end
         send_byte(directed[r].lead);
         repeat (directed[r].lf_count) send_byte(BYTE_LF);
         send_byte(directed[r].hdr_cr);
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (directed[r].ramp) begin
               send_byte(8'(i * 9 + 3));
            end else begin
               send_byte((i % 2 == 1) ? directed[r].odd_byte : directed[r].even_byte);
            end
         end
         send_byte(directed[r].trl_cr);
         send_byte(directed[r].trl_lf);
      end
      gold_held = 1'b0;

      // Random part. Most bursts are well-formed frames with random payload
      // and one to three header LFs; some of those get one byte overwritten
      // (header, trailer or anywhere) or are cut short, and the rest is plain
      // noise. A frame cut in its payload leaves the parser there, so the next
      // frame's header is eaten as data, which the parser copy follows on its own.
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         calm = (bytes_sent - random_start >= 500) && (bytes_sent - random_start < 850);
         seq.delete();
         roll = $urandom_range(99);
         if (roll < 12) begin
            repeat ($urandom_range(1, 8)) seq.push_back(noisy_byte());
         end else begin
            lf_n = $urandom_range(1, 3);
            repeat (lf_n) seq.push_back(BYTE_LF);
            seq.push_back(BYTE_CR);
            repeat (PAYLOAD_BYTES) seq.push_back(noisy_byte());
            seq.push_back(BYTE_CR);
            seq.push_back(BYTE_LF);
            if (roll >= 80) begin
               case ($urandom_range(2))
                  0:       spot = $urandom_range(lf_n);
                  1:       spot = seq.size() - 1 - $urandom_range(1);
                  default: spot = $urandom_range(seq.size() - 1);
               endcase
               if ($urandom_range(1) == 1) begin
                  seq[spot] = noisy_byte();
               end else begin
                  seq = seq[0:spot];
               end
            end
         end
         foreach (seq[i]) begin
            send_byte(seq[i]);
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain every owed reading, then give the block a few more cycles to
      // show any reading it should not produce.
      while (reading_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (failures == 0) begin
         $display("tb_sensor_frame_deframer: done, clean");
      end else begin
         $display("tb_sensor_frame_deframer: done, errors");
      end
      $finish;
   end

endmodule
